@@ sv/bar_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bar_pkg
// Shared widths, constants and types for the accelerating auto-repeat block.
// ----------------------------------------------------------------------------
package bar_pkg;

    // Port field widths
    localparam int BUTTON_W = 3;
    localparam int NOW_W    = 32;
    localparam int DELAY_W  = 16;
    localparam int EV_W     = 2;

    // Number of tracked buttons; indexes at or above this are ignored
    localparam int NUM_BUTTONS = 8;
    localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd300;

    // Held time over which the delay ramps down: 5% of base per 250 ms
    localparam int unsigned RAMP_MS   = 5000;
    localparam int          ELAPSED_W = $clog2(RAMP_MS + 1);
    localparam int          PROD1_W   = DELAY_W + ELAPSED_W;

    // ceil(p / 5000) = floor(((p + 4999) >> 3) / 625), the last step by reciprocal
    localparam int          DIV_SH    = 3;
    localparam int unsigned DIV_ODD   = RAMP_MS >> DIV_SH;
    localparam int          Y_W       = PROD1_W - DIV_SH;
    localparam int          RECIP_SH  = Y_W + $clog2(DIV_ODD);
    localparam int          RECIP_W   = Y_W + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];
    localparam int          PROD2_W   = Y_W + RECIP_W;
    localparam int          C_W       = PROD2_W - RECIP_SH;

    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_REPEAT  = 2'd3
    } t_event;

    // One button's stored state
    typedef struct packed {
        logic             level;
        logic [NOW_W-1:0] start;
        logic [NOW_W-1:0] deadline;
    } t_entry;

endpackage
`default_nettype wire

@@ sv/button_autorepeat_accelerating.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_autorepeat_accelerating
// Per-button press/release/repeat events with a repeat delay that shortens
// the longer a button is held.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one poll sample: button
//   index, level and the millisecond time. Each sample gives exactly one
//   result on the output channel (o_out_valid / i_out_ready): the event code
//   (none, press, release, repeat) and the sampled button index.
//   Path: a sample moves through s1, s2, s3, s4 and the output register.
//   Throughput: one sample per cycle when not stalled. A sample of a button
//   whose repeat event is still inside the 3 update stages waits until that
//   repeat has written its new deadline; samples of other buttons never wait
//   on it. Per-button state (level, repeat start, deadline) lives in one
//   synchronous RAM with registered read; entries are read on transfer,
//   updated in the last stage and forwarded to younger samples in flight.
//   The base delay is written through i_cfg_wr_en / i_cfg_wr_data and takes
//   effect at once; write it only while no sample is in flight.
//   Reset clears the pipeline, the output register, the base delay (300 ms)
//   and the per-entry valid bits, so every button reads as released with
//   zero times. No clearing pass is needed.
//   When the receiver stalls, the result holds in the output register and
//   the stages behind it fill up before o_in_ready drops.
// ----------------------------------------------------------------------------
module button_autorepeat_accelerating
    import bar_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [DELAY_W-1:0]  i_cfg_wr_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [BUTTON_W-1:0] i_button,
    input  wire logic                i_pressed,
    input  wire logic [NOW_W-1:0]    i_now_ms,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [EV_W-1:0]          o_event_res,
    output logic [BUTTON_W-1:0]      o_event_button
);

    function automatic logic [ADDR_W-1:0] btn_addr(input logic [BUTTON_W-1:0] b);
        logic [BUTTON_W+ADDR_W-1:0] ext;
        ext = (BUTTON_W+ADDR_W)'(b);
        return ext[ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Base delay register
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0] r_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg_wr_en) begin
            r_delay <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    //   s1: RAM data back, forward, decide the event
    //   s2: multiply base delay by held time
    //   s3: round and multiply by reciprocal of the ramp divisor
    //   s4: finish the delay, write back, hand to the output register
    // ------------------------------------------------------------------
    logic                r_s1_vld;
    logic [BUTTON_W-1:0] r_s1_btn;
    logic                r_s1_pressed;
    logic [NOW_W-1:0]    r_s1_now;

    logic                r_s2_vld, r_s3_vld, r_s4_vld;
    logic [BUTTON_W-1:0] r_s2_btn, r_s3_btn, r_s4_btn;
    t_event              r_s2_ev, r_s3_ev, r_s4_ev;
    logic                r_s2_chg, r_s3_chg, r_s4_chg;
    logic                r_s2_rep, r_s3_rep, r_s4_rep;
    t_entry              r_s2_wdata, r_s3_wdata, r_s4_wdata;
    logic                r_s2_big, r_s3_big, r_s4_big;
    logic [ELAPSED_W-1:0] r_s2_el;
    logic [PROD1_W-1:0]  r_s3_p;
    logic [PROD2_W-1:0]  r_s4_q;

    logic                r_out_vld;
    t_event              r_out_res;
    logic [BUTTON_W-1:0] r_out_btn;

    // Last edge's write, for a read that raced it
    logic                r_w_vld;
    logic [BUTTON_W-1:0] r_w_btn;
    t_entry              r_w_data;

    // State RAM
    t_entry                 r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_ent_vld;
    t_entry                 r_rd_data;
    logic                   r_rd_vld;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    logic free_out, free4, free3, free2;
    logic s1_hazard, s1_move, s4_move, s4_wr, in_acc;

    assign free_out = !r_out_vld || i_out_ready;
    assign free4    = !r_s4_vld || free_out;
    assign free3    = !r_s3_vld || free4;
    assign free2    = !r_s2_vld || free3;

    // Hold a sample while a repeat of the same button has not yet written
    // its deadline
    assign s1_hazard = r_s1_vld && (
        (r_s2_vld && r_s2_rep && (r_s2_btn == r_s1_btn)) ||
        (r_s3_vld && r_s3_rep && (r_s3_btn == r_s1_btn)) ||
        (r_s4_vld && r_s4_rep && (r_s4_btn == r_s1_btn)));

    assign s1_move    = r_s1_vld && !s1_hazard && free2;
    assign o_in_ready = !r_s1_vld || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;
    assign s4_move    = r_s4_vld && free_out;
    assign s4_wr      = r_s4_chg || r_s4_rep;

    // ------------------------------------------------------------------
    // RAM access: read the arriving sample's entry, or re-read the held one
    // ------------------------------------------------------------------
    logic [BUTTON_W-1:0] rd_btn;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    t_entry              n_s4_wdata;

    assign rd_btn  = in_acc ? i_button : r_s1_btn;
    assign rd_addr = btn_addr(rd_btn);
    assign wr_addr = btn_addr(r_s4_btn);

    always_ff @(posedge i_clk) begin
        if (s4_move && s4_wr) begin
            r_mem[wr_addr] <= n_s4_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_ent_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_w_vld   <= 1'b0;
        end else begin
            if (s4_move && s4_wr) begin
                r_ent_vld[wr_addr] <= 1'b1;
            end
            r_w_vld <= s4_move && s4_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_btn  <= r_s4_btn;
        r_w_data <= n_s4_wdata;
    end

    // ------------------------------------------------------------------
    // s1: forward newest pending state, then classify the sample
    // ------------------------------------------------------------------
    t_entry             s1_cur;
    logic               s1_in_range, s1_chg, s1_rep;
    t_event             s1_ev;
    logic [NOW_W-1:0]   s1_elapsed;
    t_entry             s1_wdata;

    always_comb begin
        // oldest source first, newest overrides
        s1_cur = r_rd_vld ? r_rd_data : '0;
        if (r_w_vld && (r_w_btn == r_s1_btn)) begin
            s1_cur = r_w_data;
        end
        if (r_s4_vld && r_s4_chg && (r_s4_btn == r_s1_btn)) begin
            s1_cur = r_s4_wdata;
        end
        if (r_s3_vld && r_s3_chg && (r_s3_btn == r_s1_btn)) begin
            s1_cur = r_s3_wdata;
        end
        if (r_s2_vld && r_s2_chg && (r_s2_btn == r_s1_btn)) begin
            s1_cur = r_s2_wdata;
        end
    end

    assign s1_in_range = (32'(r_s1_btn) < 32'(NUM_BUTTONS));
    assign s1_chg      = s1_in_range && (r_s1_pressed != s1_cur.level);
    assign s1_rep      = s1_in_range && !s1_chg && r_s1_pressed
                         && (s1_cur.deadline <= r_s1_now);
    assign s1_elapsed  = r_s1_now - s1_cur.start;

    always_comb begin
        s1_ev = EV_NONE;
        if (s1_chg) begin
            s1_ev = r_s1_pressed ? EV_PRESS : EV_RELEASE;
        end else if (s1_rep) begin
            s1_ev = EV_REPEAT;
        end
    end

    // Level change data is final here; a repeat fills its deadline in s4
    assign s1_wdata.level    = r_s1_pressed;
    assign s1_wdata.start    = s1_chg ? r_s1_now : s1_cur.start;
    assign s1_wdata.deadline = r_s1_now + NOW_W'(r_delay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_btn     <= i_button;
            r_s1_pressed <= i_pressed;
            r_s1_now     <= i_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // s2 .. s4 and output register
    // ------------------------------------------------------------------
    logic [PROD1_W-1:0] s2_p;
    logic [PROD1_W-1:0] s3_x;
    logic [Y_W-1:0]     s3_y;
    logic [C_W-1:0]     s4_c;
    logic [DELAY_W-1:0] s4_t, s4_delay;
    logic [DELAY_W+1:0] s4_four_t;
    logic               s4_floor;

    assign s2_p = PROD1_W'(r_delay) * PROD1_W'(r_s2_el);

    assign s3_x = r_s3_p + PROD1_W'(RAMP_MS - 1);
    assign s3_y = s3_x[PROD1_W-1:DIV_SH];

    assign s4_c      = r_s4_q[PROD2_W-1:RECIP_SH];
    assign s4_t      = DELAY_W'(C_W'(r_delay) - s4_c);
    assign s4_four_t = {s4_t, 2'b00};
    assign s4_floor  = r_s4_big || (s4_four_t < (DELAY_W+2)'(r_delay));
    assign s4_delay  = s4_floor ? {2'b00, r_delay[DELAY_W-1:2]} : s4_t;

    always_comb begin
        n_s4_wdata = r_s4_wdata;
        if (r_s4_rep) begin
            n_s4_wdata.deadline = r_s4_wdata.deadline - NOW_W'(r_delay)
                                  + NOW_W'(s4_delay);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (free2) begin
                r_s2_vld <= s1_move;
            end
            if (free3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (free4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (free_out) begin
                r_out_vld <= r_s4_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free2) begin
            r_s2_btn   <= r_s1_btn;
            r_s2_ev    <= s1_ev;
            r_s2_chg   <= s1_chg;
            r_s2_rep   <= s1_rep;
            r_s2_wdata <= s1_wdata;
            r_s2_big   <= (s1_elapsed > NOW_W'(RAMP_MS));
            r_s2_el    <= s1_elapsed[ELAPSED_W-1:0];
        end
        if (free3) begin
            r_s3_btn   <= r_s2_btn;
            r_s3_ev    <= r_s2_ev;
            r_s3_chg   <= r_s2_chg;
            r_s3_rep   <= r_s2_rep;
            r_s3_wdata <= r_s2_wdata;
            r_s3_big   <= r_s2_big;
            r_s3_p     <= s2_p;
        end
        if (free4) begin
            r_s4_btn   <= r_s3_btn;
            r_s4_ev    <= r_s3_ev;
            r_s4_chg   <= r_s3_chg;
            r_s4_rep   <= r_s3_rep;
            r_s4_wdata <= r_s3_wdata;
            r_s4_big   <= r_s3_big;
            r_s4_q     <= PROD2_W'(s3_y) * PROD2_W'(RECIP_M);
        end
        if (free_out) begin
            r_out_res <= r_s4_ev;
            r_out_btn <= r_s4_btn;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_event_res    = r_out_res;
    assign o_event_button = r_out_btn;

endmodule
`default_nettype wire

@@ sv/bar_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bar_checker
// Port-level checks for the accelerating auto-repeat block.
// ----------------------------------------------------------------------------
module bar_checker
    import bar_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [EV_W-1:0]     o_event_res,
    input wire logic [BUTTON_W-1:0] o_event_button
);

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_event_res) && $stable(o_event_button))
        else $error("stalled result dropped or changed");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // Empty pipeline out of reset takes a sample at once
    a_rst_ready: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> o_in_ready)
        else $error("not ready after reset");

    // With the receiver open, a repeat interlock ends once the repeat has written back from s4
    a_stall_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready && $past(i_out_ready) && $past(i_out_ready, 2)
            && $past(i_out_ready, 3) && $past(i_rst_n, 3)
            && $past(i_rst_n, 2) && $past(i_rst_n)
        |-> o_in_ready || $past(o_in_ready) || $past(o_in_ready, 2)
            || $past(o_in_ready, 3))
        else $error("input held off too long");

endmodule

bind button_autorepeat_accelerating bar_checker u_bar_checker (.*);
`default_nettype wire

@@ bench/button_autorepeat_accelerating_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_autorepeat_accelerating_checker
// Watches the sample, result and delay-write ports of the auto-repeat block.
// Predicts the event of every transferred sample and compares it, in order,
// with the results that leave the block.
// ----------------------------------------------------------------------------
module button_autorepeat_accelerating_checker
    import bar_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [DELAY_W-1:0]  i_cfg_wr_data,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire logic [BUTTON_W-1:0] i_button,
    input  wire logic                i_pressed,
    input  wire logic [NOW_W-1:0]    i_now_ms,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic [EV_W-1:0]     i_event_res,
    input  wire logic [BUTTON_W-1:0] i_event_button,
    output int                       o_pending,
    output int                       o_fail_count
);

    typedef struct packed {
        t_event              code;
        logic [BUTTON_W-1:0] button;
    } t_expect;

    // Predictor's own copy of the base delay and per-button state
    logic [DELAY_W-1:0] base_delay;
    logic               held_level [NUM_BUTTONS];
    logic [NOW_W-1:0]   hold_start [NUM_BUTTONS];
    logic [NOW_W-1:0]   due_time   [NUM_BUTTONS];

    t_expect awaited_events [$];
    int      fails = 0;

    // Delay to the next repeat: base minus base*held/5000 (rounded up),
    // never below a quarter of the base.
    function automatic logic [NOW_W-1:0] accel_delay(input logic [DELAY_W-1:0] base,
                                                     input logic [NOW_W-1:0] held);
        logic [63:0] prod;
        logic [63:0] cut;
        logic [63:0] trimmed;
        logic [63:0] quarter;
        prod    = 64'(base) * 64'(held);
        cut     = (prod + 64'(RAMP_MS) - 64'd1) / 64'(RAMP_MS);
        quarter = 64'(base >> 2);
        if (cut > 64'(base)) begin
            return quarter[NOW_W-1:0];
        end
        trimmed = 64'(base) - cut;
        if ((trimmed << 2) < 64'(base)) begin
            return quarter[NOW_W-1:0];
        end
        return trimmed[NOW_W-1:0];
    endfunction

    // Advance the state by one sample and return the event it gives.
    function automatic t_expect next_event(input logic [BUTTON_W-1:0] btn,
                                           input logic lvl,
                                           input logic [NOW_W-1:0] now);
        t_expect          res;
        logic [NOW_W-1:0] base_ext;
        res.code   = EV_NONE;
        res.button = btn;
        base_ext   = NOW_W'(base_delay);
        if (int'(btn) < NUM_BUTTONS) begin
            if (lvl != held_level[btn]) begin
                res.code        = lvl ? EV_PRESS : EV_RELEASE;
                hold_start[btn] = now;
                due_time[btn]   = now + base_ext;
                held_level[btn] = lvl;
            end else if (lvl && due_time[btn] <= now) begin
                due_time[btn] = now + accel_delay(base_delay, now - hold_start[btn]);
                res.code      = EV_REPEAT;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_expect want;
        if (!i_rst_n) begin
            base_delay = DELAY_RESET;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                held_level[i] = 1'b0;
                hold_start[i] = '0;
                due_time[i]   = '0;
            end
            awaited_events.delete();
        end else begin
            if (i_cfg_wr_en) begin
                base_delay = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                awaited_events.insert(awaited_events.size(),
                                      next_event(i_button, i_pressed, i_now_ms));
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_events.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual event %0d button %0d",
                             $time, i_event_res, i_event_button);
                end else begin
                    want = awaited_events.pop_front();
                    if (i_event_res !== want.code) begin
                        fails++;
                        $display("%0t: event code mismatch, expected %0d (%s), actual %0d",
                                 $time, want.code, want.code.name(), i_event_res);
                    end
                    if (i_event_button !== want.button) begin
                        fails++;
                        $display("%0t: event button mismatch, expected %0d, actual %0d",
                                 $time, want.button, i_event_button);
                    end
                end
            end
        end
        o_pending    <= awaited_events.size();
        o_fail_count <= fails;
    end

endmodule

@@ bench/button_autorepeat_accelerating_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_autorepeat_accelerating_tb
// Drives poll samples into the auto-repeat block: a directed opening over
// press, release, repeat, the delay floor and time wrap, then random phases
// of held and toggled buttons under several base delays. Both channels
// idle at random; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module button_autorepeat_accelerating_tb;
    import bar_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 6;
    localparam int NOISE_PCT     = 8;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 112;
    localparam int SETTLE_CYCLES = 8;     // pipeline depth plus margin
    localparam int CALM_PHASE    = 5;     // phase run with no idling at all
    localparam int RANDOM_PHASE  = 7;     // phase with a random base delay
    localparam longint TIMEOUT_NS = 2_000_000;

    // Base delay of each random phase; phase 0 keeps the reset value
    localparam logic [DELAY_W-1:0] PHASE_DELAY [RAND_PHASES] =
        '{16'd300, 16'd0, 16'd65535, 16'd1, 16'd3, 16'd5, 16'd1000, 16'd0, 16'd300};

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [DELAY_W-1:0]  cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [BUTTON_W-1:0] button;
    logic                pressed;
    logic [NOW_W-1:0]    now_ms;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [EV_W-1:0]     event_res;
    logic [BUTTON_W-1:0] event_button;
    int                  pending;
    int                  fail_count;

    bit                  calm = 1'b0;         // suppress idling on both sides
    logic                drive_level [NUM_BUTTONS];
    logic [NOW_W-1:0]    clock_ms;
    logic [DELAY_W-1:0]  cur_delay;

    button_autorepeat_accelerating u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_button       (button),
        .i_pressed      (pressed),
        .i_now_ms       (now_ms),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_event_res    (event_res),
        .o_event_button (event_button)
    );

    button_autorepeat_accelerating_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_button       (button),
        .i_pressed      (pressed),
        .i_now_ms       (now_ms),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_event_res    (event_res),
        .i_event_button (event_button),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Receiver: stall now and then, except during the calm stretch
    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Offer one sample and hold it until the transfer. Entered and left at a
    // falling edge, so valid stays high across back-to-back samples.
    task automatic poll(input logic [BUTTON_W-1:0] b, input logic p,
                        input logic [NOW_W-1:0] t);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        button   <= b;
        pressed  <= p;
        now_ms   <= t;
        drive_level[b] = p;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has left the block
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the base delay while the block is idle
    task automatic set_delay(input logic [DELAY_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cur_delay = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned         step_max;
        int unsigned         hot;
        logic [BUTTON_W-1:0] b;
        logic                p;
        logic [NOW_W-1:0]    t;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        button      = '0;
        pressed     = 1'b0;
        now_ms      = '0;
        cur_delay   = DELAY_RESET;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            drive_level[i] = 1'b0;
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening, base delay at its reset value of 300 ms.
        poll(3'd0, 1'b1, 32'd1000);           // press
        poll(3'd0, 1'b1, 32'd1299);           // held, deadline one short
        poll(3'd0, 1'b1, 32'd1300);           // repeat, mildly shortened delay
        poll(3'd0, 1'b1, 32'd5000);           // shortened below the quarter floor
        poll(3'd0, 1'b1, 32'd2000000);        // held so long the cut exceeds base
        poll(3'd0, 1'b0, 32'd2000001);        // release
        poll(3'd0, 1'b0, 32'd2000001);        // released and unchanged
        poll(3'd0, 1'b0, 32'hFFFF_FFFF);      // released, deadline long past
        poll(3'd7, 1'b1, 32'hFFFF_FF00);      // press, deadline wraps past zero
        poll(3'd7, 1'b1, 32'hFFFF_FF01);      // wrapped deadline repeats at once
        poll(3'd7, 1'b1, 32'd5);              // clock wrapped, not yet due
        poll(3'd7, 1'b1, 32'd44);             // repeat with held time across wrap
        poll(3'd7, 1'b0, 32'd44);
        poll(3'd3, 1'b1, 32'd0);              // press at time zero
        poll(3'd3, 1'b1, 32'd300);            // repeat exactly at the deadline
        poll(3'd3, 1'b0, 32'hFFFF_FFFF);      // release at the largest time
        poll(3'd5, 1'b0, 32'd0);              // never pressed
        poll(3'd5, 1'b1, 32'hAAAA_AAAA);
        poll(3'd5, 1'b1, 32'h5555_5555);      // time went backwards, not due
        poll(3'd5, 1'b0, 32'h5555_5555);

        clock_ms = 32'd3_000_000;

        // Random phases: mostly buttons held and toggled against a rising
        // clock, with some noise samples carrying arbitrary times.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RANDOM_PHASE) begin
                set_delay(DELAY_W'($urandom_range(0, 65535)));
            end else if (ph != 0) begin
                set_delay(PHASE_DELAY[ph]);
            end
            calm = (ph == CALM_PHASE);
            // Start some phases just short of the clock wrap
            if (ph == 2 || ph == 6) begin
                clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
            end
            // Keep time steps in scale with the delay so repeats stay common
            step_max = int'(cur_delay) / 3 + 4;
            // Focus on a few buttons so that holds last long enough to accelerate
            hot = $urandom_range(0, NUM_BUTTONS - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < NOISE_PCT) begin
                    b = BUTTON_W'($urandom_range(0, NUM_BUTTONS - 1));
                    p = 1'($urandom_range(0, 1));
                    t = $urandom();
                end else begin
                    b = BUTTON_W'($urandom_range(0, hot));
                    p = drive_level[b] ^ ($urandom_range(0, 15) == 0);
                    clock_ms = clock_ms + NOW_W'($urandom_range(0, step_max));
                    t = clock_ms;
                end
                poll(b, p, t);
            end
        end
        calm = 1'b0;

        settle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/bar_pkg.sv
sv/button_autorepeat_accelerating.sv
sv/bar_checker.sv
bench/button_autorepeat_accelerating_checker.sv
bench/button_autorepeat_accelerating_tb.sv
